>>> design/ocm_pkg.sv
// Shared types and constants for the optimizer convergence monitor.
// No dependencies; imported by every module of the block except ocm_ram.
package ocm_pkg;

  localparam int DEFAULT_VECTOR_DEPTH = 256;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int OUT_DEPTH = 2;

  typedef enum logic {
    CMD_ELEMENT = 1'b0,
    CMD_TICK    = 1'b1
  } command_t;

  typedef enum logic [2:0] {
    RSN_NONE       = 3'd0,
    RSN_ITER       = 3'd1,
    RSN_RUNTIME    = 3'd2,
    RSN_ELEM_DELTA = 3'd3,
    RSN_AVG_DELTA  = 3'd4,
    RSN_ELEM_GRAD  = 3'd5,
    RSN_AVG_GRAD   = 3'd6,
    RSN_OBJECTIVE  = 3'd7
  } reason_t;

  typedef enum logic [2:0] {
    CFG_MAX_ITER   = 3'd0,
    CFG_MAX_TICKS  = 3'd1,
    CFG_ELEM_DELTA = 3'd2,
    CFG_AVG_DELTA  = 3'd3,
    CFG_ELEM_GRAD  = 3'd4,
    CFG_AVG_GRAD   = 3'd5,
    CFG_OBJ_DELTA  = 3'd6,
    CFG_VEC_LEN    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]        max_iterations;
    logic [47:0]        max_runtime_ticks;
    logic signed [31:0] min_element_delta;
    logic signed [31:0] min_average_delta;
    logic signed [31:0] min_element_gradient;
    logic signed [31:0] min_average_gradient;
    logic signed [31:0] min_objective_delta;
    logic [8:0]         vector_length;
  } cfg_t;

  // request as it travels from the front queue to the back end
  typedef struct packed {
    logic        tick;
    logic        last;
    logic [31:0] param;
    logic [31:0] grad;
    logic [31:0] obj;
  } item_t;

  typedef struct packed {
    logic        converged;
    reason_t     reason;
    logic [31:0] iteration;
  } result_t;

endpackage

>>> design/ocm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ocm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> design/ocm_front.sv
// Front end: configuration registers, request classification (tick or element,
// element slot, last of iteration) and the short request queue. Uses ocm_pkg.
module ocm_front import ocm_pkg::*; #(
  parameter int VECTOR_DEPTH = DEFAULT_VECTOR_DEPTH,
  localparam int LEN_W = $clog2(VECTOR_DEPTH + 1),
  localparam int IDX_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [47:0]      cfg_data,
  input  logic             push,
  output logic             full,
  input  logic             command,
  input  logic [31:0]      param_value,
  input  logic [31:0]      gradient_value,
  input  logic [31:0]      objective,
  output cfg_t             cfg,
  output logic [LEN_W-1:0] eff_len,
  output logic             q_valid,
  input  logic             q_pop,
  output item_t            q_item,
  output logic [IDX_W-1:0] q_idx
);
  item_t            qmem [Q_DEPTH];
  logic [IDX_W-1:0] qidx [Q_DEPTH];
  logic [Q_PTR_W-1:0] head, tail;
  logic [Q_PTR_W:0]   count;
  logic [LEN_W-1:0]   element_index;
  logic [31:0]        vl32;
  logic               accept, is_tick, is_last;

  assign cfg_ready = 1'b1;
  assign full      = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign accept    = push && !full;
  assign is_tick   = (command == CMD_TICK);
  assign is_last   = ((LEN_W + 1)'(element_index) + 1'b1) >= (LEN_W + 1)'(eff_len);
  assign vl32      = 32'(cfg.vector_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_iterations       <= '0;
      cfg.max_runtime_ticks    <= '1;
      cfg.min_element_delta    <= 32'sh8000_0000;
      cfg.min_average_delta    <= 32'sh8000_0000;
      cfg.min_element_gradient <= 32'sh8000_0000;
      cfg.min_average_gradient <= 32'sh8000_0000;
      cfg.min_objective_delta  <= 32'sh8000_0000;
      cfg.vector_length        <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_ITER:   cfg.max_iterations       <= cfg_data[31:0];
        CFG_MAX_TICKS:  cfg.max_runtime_ticks    <= cfg_data;
        CFG_ELEM_DELTA: cfg.min_element_delta    <= cfg_data[31:0];
        CFG_AVG_DELTA:  cfg.min_average_delta    <= cfg_data[31:0];
        CFG_ELEM_GRAD:  cfg.min_element_gradient <= cfg_data[31:0];
        CFG_AVG_GRAD:   cfg.min_average_gradient <= cfg_data[31:0];
        CFG_OBJ_DELTA:  cfg.min_objective_delta  <= cfg_data[31:0];
        CFG_VEC_LEN:    cfg.vector_length        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // effective length: zero acts as one, clamp to store depth
  always_comb begin
    if (vl32 == 32'd0) begin
      eff_len = LEN_W'(1);
    end else if (vl32 > 32'(VECTOR_DEPTH)) begin
      eff_len = LEN_W'(VECTOR_DEPTH);
    end else begin
      eff_len = LEN_W'(vl32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_index <= '0;
    end else if (accept && !is_tick) begin
      element_index <= is_last ? '0 : element_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qmem[tail] <= '{tick: is_tick, last: is_last && !is_tick, param: param_value,
                      grad: gradient_value, obj: objective};
      qidx[tail] <= IDX_W'(element_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) tail <= tail + 1'b1;
      if (q_pop)  head <= head + 1'b1;
      count <= count + (Q_PTR_W + 1)'(accept) - (Q_PTR_W + 1)'(q_pop);
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = qmem[head];
  assign q_idx   = qidx[head];
endmodule

>>> design/ocm_back.sv
// Back end: reference read from the two banks, change/gradient accumulation,
// verdict on the last element, and the result queue. Uses ocm_pkg, ocm_ram.
module ocm_back import ocm_pkg::*; #(
  parameter int VECTOR_DEPTH = DEFAULT_VECTOR_DEPTH,
  localparam int LEN_W = $clog2(VECTOR_DEPTH + 1),
  localparam int IDX_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic [LEN_W-1:0] eff_len,
  input  logic             q_valid,
  output logic             q_pop,
  input  item_t            q_item,
  input  logic [IDX_W-1:0] q_idx,
  output logic             empty,
  input  logic             pop,
  output logic             converged,
  output logic [2:0]       reason,
  output logic [31:0]      iteration
);
  localparam int SUM_W = 31 + LEN_W;
  localparam int PW    = 33 + LEN_W;

  // saturating magnitude of a 33-bit signed difference
  function automatic logic [30:0] sat_abs(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return (m > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : m[30:0];
  endfunction

  logic                 adv;
  logic                 rd_valid;
  item_t                rd_item;
  logic [IDX_W-1:0]     rd_idx;
  logic                 fwd, fwd_bank;
  logic [31:0]          fwd_data, bank0_q, bank1_q, ref_val;
  logic                 bank_select, initialized;
  logic [31:0]          previous_objective, iteration_count;
  logic [47:0]          tick_count;
  logic [30:0]          max_param_change, max_gradient_mag;
  logic [SUM_W-1:0]     sum_param_change, sum_gradient_mag;
  logic signed [PW-1:0] lim_avg_delta, lim_avg_grad;

  logic [30:0]          d, gm, max_p_next, max_g_next, obj_mag;
  logic [SUM_W-1:0]     sum_p_next, sum_g_next;
  logic [31:0]          iter_next;
  reason_t              rsn;
  logic                 keep_ref, wr_elem, out_push;

  result_t              oq [OUT_DEPTH];
  logic                 oq_head, oq_tail;
  logic [1:0]           oq_count;

  assign adv   = (oq_count != 2'(OUT_DEPTH));
  assign q_pop = adv && q_valid;

  // averages compare sum against threshold times length
  always_ff @(posedge clk) begin
    lim_avg_delta <= PW'(cfg.min_average_delta * $signed({1'b0, eff_len}));
    lim_avg_grad  <= PW'(cfg.min_average_gradient * $signed({1'b0, eff_len}));
  end

  assign wr_elem = adv && rd_valid && !rd_item.tick;

  ocm_ram #(.WIDTH(32), .DEPTH(VECTOR_DEPTH)) u_bank0 (
    .clk, .we(wr_elem && bank_select), .waddr(rd_idx), .wdata(rd_item.param),
    .re(q_pop), .raddr(q_idx), .rdata(bank0_q)
  );
  ocm_ram #(.WIDTH(32), .DEPTH(VECTOR_DEPTH)) u_bank1 (
    .clk, .we(wr_elem && !bank_select), .waddr(rd_idx), .wdata(rd_item.param),
    .re(q_pop), .raddr(q_idx), .rdata(bank1_q)
  );

  // read stage; forward a write that lands at the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (adv) begin
      rd_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_item  <= q_item;
      rd_idx   <= q_idx;
      fwd      <= wr_elem && (rd_idx == q_idx);
      fwd_bank <= !bank_select;
      fwd_data <= rd_item.param;
    end
  end

  always_comb begin
    if (fwd && (fwd_bank == bank_select)) begin
      ref_val = fwd_data;
    end else begin
      ref_val = bank_select ? bank1_q : bank0_q;
    end
    d  = sat_abs($signed({rd_item.param[31], rd_item.param}) -
                 $signed({ref_val[31], ref_val}));
    gm = sat_abs($signed({rd_item.grad[31], rd_item.grad}));
    max_p_next = (d > max_param_change) ? d : max_param_change;
    max_g_next = (gm > max_gradient_mag) ? gm : max_gradient_mag;
    sum_p_next = sum_param_change + SUM_W'(d);
    sum_g_next = sum_gradient_mag + SUM_W'(gm);
    iter_next  = (&iteration_count) ? iteration_count : iteration_count + 1'b1;
    obj_mag    = sat_abs($signed({rd_item.obj[31], rd_item.obj}) -
                         $signed({previous_objective[31], previous_objective}));
  end

  always_comb begin
    keep_ref = 1'b0;
    if ((cfg.max_iterations != '0) && (iter_next >= cfg.max_iterations)) begin
      rsn = RSN_ITER;
    end else if (tick_count > cfg.max_runtime_ticks) begin
      rsn = RSN_RUNTIME;
    end else if (!initialized) begin
      rsn = RSN_NONE;
      keep_ref = 1'b1;
    end else if ($signed({1'b0, max_p_next}) < cfg.min_element_delta) begin
      rsn = RSN_ELEM_DELTA;
    end else if ($signed(PW'(sum_p_next)) < lim_avg_delta) begin
      rsn = RSN_AVG_DELTA;
    end else if ($signed({1'b0, max_g_next}) < cfg.min_element_gradient) begin
      rsn = RSN_ELEM_GRAD;
    end else if ($signed(PW'(sum_g_next)) < lim_avg_grad) begin
      rsn = RSN_AVG_GRAD;
    end else if ($signed({1'b0, obj_mag}) < cfg.min_objective_delta) begin
      rsn = RSN_OBJECTIVE;
    end else begin
      rsn = RSN_NONE;
      keep_ref = 1'b1;
    end
  end

  assign out_push = wr_elem && rd_item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select        <= 1'b0;
      previous_objective <= '0;
      initialized        <= 1'b0;
      iteration_count    <= '0;
      tick_count         <= '0;
      max_param_change   <= '0;
      sum_param_change   <= '0;
      max_gradient_mag   <= '0;
      sum_gradient_mag   <= '0;
    end else if (adv && rd_valid) begin
      if (rd_item.tick) begin
        if (!(&tick_count)) tick_count <= tick_count + 1'b1;
      end else if (rd_item.last) begin
        iteration_count  <= iter_next;
        max_param_change <= '0;
        sum_param_change <= '0;
        max_gradient_mag <= '0;
        sum_gradient_mag <= '0;
        if (keep_ref) begin
          bank_select        <= !bank_select;
          previous_objective <= rd_item.obj;
          initialized        <= 1'b1;
        end
      end else begin
        max_param_change <= max_p_next;
        sum_param_change <= sum_p_next;
        max_gradient_mag <= max_g_next;
        sum_gradient_mag <= sum_g_next;
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (out_push) begin
      oq[oq_tail] <= '{converged: (rsn != RSN_NONE), reason: rsn, iteration: iter_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_head  <= 1'b0;
      oq_tail  <= 1'b0;
      oq_count <= '0;
    end else begin
      if (out_push)        oq_tail <= !oq_tail;
      if (pop && !empty)   oq_head <= !oq_head;
      oq_count <= oq_count + 2'(out_push) - 2'(pop && !empty);
    end
  end

  assign empty     = (oq_count == '0);
  assign converged = oq[oq_head].converged;
  assign reason    = oq[oq_head].reason;
  assign iteration = oq[oq_head].iteration;
endmodule

>>> design/optimizer_convergence_monitor.sv
// Top level of the optimizer convergence monitor: front end, back end.
// Depends on ocm_pkg, ocm_front, ocm_back (and ocm_ram through ocm_back).
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  request  | push / full            | command, param_value, gradient_value,
//           |                        | objective
//  result   | pop / empty            | converged, reason, iteration
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle sustained while the result queue has room; an accepted
// request is written to the four-entry queue, then the back end reads the bank
// and records the verdict, and a last element's result goes to the result queue.
// Synchronous reset clears control state; the parameter store is not cleared
// (an unwritten reference entry reads as whatever the RAM holds).
// The back end stalls only when the two-entry result queue is full; the front
// keeps taking requests until its queue fills. cfg_ready is always high.
module optimizer_convergence_monitor import ocm_pkg::*; #(
  parameter int VECTOR_DEPTH = DEFAULT_VECTOR_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic        command,
  input  logic [31:0] param_value,
  input  logic [31:0] gradient_value,
  input  logic [31:0] objective,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic        converged,
  output logic [2:0]  reason,
  output logic [31:0] iteration,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  localparam int LEN_W = $clog2(VECTOR_DEPTH + 1);
  localparam int IDX_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

  cfg_t             cfg;
  logic [LEN_W-1:0] eff_len;
  logic             q_valid, q_pop;
  item_t            q_item;
  logic [IDX_W-1:0] q_idx;

  // classification: tick vs element, slot index and end of iteration
  ocm_front #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .push, .full, .command, .param_value, .gradient_value, .objective,
    .cfg, .eff_len, .q_valid, .q_pop, .q_item, .q_idx
  );

  // execution: reference compare, accumulation, verdict, result queue
  ocm_back #(.VECTOR_DEPTH(VECTOR_DEPTH)) u_back (
    .clk, .rst, .cfg, .eff_len, .q_valid, .q_pop, .q_item, .q_idx,
    .empty, .pop, .converged, .reason, .iteration
  );
endmodule

>>> design/ocm_checker.sv
// Port-level checks for optimizer_convergence_monitor, with its bind.
// Depends on ocm_pkg reason codes.
module ocm_checker import ocm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        converged,
  input logic [2:0]  reason,
  input logic [31:0] iteration,
  input logic        cfg_ready
);
  // converged flag agrees with the reason code
  a_conv_reason: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (converged == (reason != RSN_NONE)))
    else $error("converged and reason disagree");

  // results count iterations from one
  a_iter_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (iteration != 32'd0))
    else $error("result with zero iteration");

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (empty && !full))
    else $error("queue not empty after reset");

  // a waiting result holds still until popped
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(converged) && $stable(reason) &&
                          $stable(iteration)))
    else $error("waiting result changed");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");
endmodule

bind optimizer_convergence_monitor ocm_checker u_ocm_checker (
  .clk, .rst, .push, .full, .empty, .pop, .converged, .reason, .iteration, .cfg_ready
);
